// File: rtl/core/tilt_ball_bounce_step_unit_defines.svh
// ----------------------------------------------------------------------------
// tilt ball bounce step unit assertion macros
// concurrent checks on the rising clock edge, held off while reset is low
// ----------------------------------------------------------------------------
`ifndef TILT_BALL_BOUNCE_STEP_UNIT_DEFINES_SVH
`define TILT_BALL_BOUNCE_STEP_UNIT_DEFINES_SVH

// same-cycle implication
`define TBBS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tbbs check failed");

// next-cycle implication
`define TBBS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tbbs check failed");

`endif

// File: rtl/core/tbbs_pkg.sv
// ----------------------------------------------------------------------------
// tbbs_pkg
// types, microcode table and constants of the tilt ball bounce step unit
// ----------------------------------------------------------------------------
`default_nettype none

package tbbs_pkg;

    // field widths
    localparam int DT_W     = 10;
    localparam int TILT_W   = 8;
    localparam int POS_X_W  = 9;
    localparam int POS_Y_W  = 8;
    localparam int POS_W    = 10;
    localparam int VEL_W    = 32;
    localparam int GRAV_W   = 16;
    localparam int REB_W    = 9;
    localparam int STOP_W   = 16;
    localparam int SINE_W   = 16;
    localparam int MAG_W    = 7;

    // arithmetic widths
    localparam int T_W      = 22;
    localparam int MUL_A_W  = 32;
    localparam int MUL_B_W  = 28;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int AMAG_W   = 24;
    localparam int ATMAG_W  = 30;
    localparam int VT_W     = 37;
    localparam int HALF_W   = 35;
    localparam int DAMP_W   = 32;
    localparam int SUM_W    = 40;
    localparam int P_W      = SUM_W - 16;
    localparam int VSUM_W   = 35;

    // physics constants
    localparam int TILT_MAX        = 70;
    localparam int ANGLE_FULL      = 90;
    localparam int SINE_STEP_MILLI = 17;
    localparam int TIME_DIV        = 30;
    localparam logic [MUL_B_W-1:0] TIME_RECIP = 28'd143165576;  // floor(2^32 / 30)

    // config port
    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;
    localparam logic [REG_IDX_W-1:0] REG_GRAVITY = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_REBOUND = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_STOP    = 2'd2;

    localparam logic [GRAV_W-1:0] GRAVITY_RST = 16'd2560;
    localparam logic [REB_W-1:0]  REBOUND_RST = 9'd128;
    localparam logic [STOP_W-1:0] STOP_RST    = 16'd256;
    localparam logic [POS_W-1:0]  BALL_X_RST  = 10'd160;
    localparam logic [POS_W-1:0]  BALL_Y_RST  = 10'd120;

    // sine of the angle that each saturated tilt magnitude maps to
    typedef logic [TILT_MAX:0][SINE_W-1:0] sine_rom_t;

    function automatic sine_rom_t build_sine_of_tilt();
        sine_rom_t   rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] r;
        longint      sum;
        int          ang;
        for (int m = 0; m <= TILT_MAX; m++) begin
            ang  = (m * ANGLE_FULL) / TILT_MAX;
            x    = ((64'(ang) * 64'(SINE_STEP_MILLI)) << 30) / 64'd1000;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 7; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            r = (64'(sum) + 64'd8192) >> 14;
            rom[m] = (r > 64'd65535) ? 16'hFFFF : r[SINE_W-1:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_OF_TILT = build_sine_of_tilt();

    // microcode fields
    localparam int STEP_W = 4;

    localparam logic [1:0] COND_NONE       = 2'd0;
    localparam logic [1:0] COND_WAIT_IN    = 2'd1;
    localparam logic [1:0] COND_OUT_BUSY   = 2'd2;
    localparam logic [1:0] COND_AXIS_FIRST = 2'd3;

    localparam logic [2:0] MA_X     = 3'd0;
    localparam logic [2:0] MA_GRAV  = 3'd1;
    localparam logic [2:0] MA_AMAG  = 3'd2;
    localparam logic [2:0] MA_VMAG  = 3'd3;
    localparam logic [2:0] MA_ATMAG = 3'd4;

    localparam logic [1:0] MB_RECIP = 2'd0;
    localparam logic [1:0] MB_SINE  = 2'd1;
    localparam logic [1:0] MB_TIME  = 2'd2;
    localparam logic [1:0] MB_REB   = 2'd3;

    localparam logic [3:0] WR_NONE  = 4'd0;
    localparam logic [3:0] WR_IN    = 4'd1;
    localparam logic [3:0] WR_T     = 4'd2;
    localparam logic [3:0] WR_AMAG  = 4'd3;
    localparam logic [3:0] WR_VT    = 4'd4;
    localparam logic [3:0] WR_AT    = 4'd5;
    localparam logic [3:0] WR_DAMP  = 4'd6;
    localparam logic [3:0] WR_HALF  = 4'd7;
    localparam logic [3:0] WR_SUM   = 4'd8;
    localparam logic [3:0] WR_POS   = 4'd9;
    localparam logic [3:0] WR_STATE = 4'd10;
    localparam logic [3:0] WR_OUT   = 4'd11;

    // program steps
    localparam logic [STEP_W-1:0] ST_WAIT  = 4'd0;
    localparam logic [STEP_W-1:0] ST_TMUL  = 4'd1;
    localparam logic [STEP_W-1:0] ST_TFIX  = 4'd2;
    localparam logic [STEP_W-1:0] ST_GMUL  = 4'd3;
    localparam logic [STEP_W-1:0] ST_VTMUL = 4'd4;
    localparam logic [STEP_W-1:0] ST_ATMUL = 4'd5;
    localparam logic [STEP_W-1:0] ST_DMUL  = 4'd6;
    localparam logic [STEP_W-1:0] ST_HMUL  = 4'd7;
    localparam logic [STEP_W-1:0] ST_HALF  = 4'd8;
    localparam logic [STEP_W-1:0] ST_SUM   = 4'd9;
    localparam logic [STEP_W-1:0] ST_POS   = 4'd10;
    localparam logic [STEP_W-1:0] ST_UPD   = 4'd11;
    localparam logic [STEP_W-1:0] ST_OUT   = 4'd12;

    typedef struct packed {
        logic [1:0]        cond;
        logic [STEP_W-1:0] target;
        logic              last;
        logic              mul_en;
        logic [2:0]        mul_a;
        logic [1:0]        mul_b;
        logic [3:0]        wr;
    } ctrl_t;

    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '{cond: COND_NONE, target: ST_WAIT, last: 1'b0, mul_en: 1'b0,
              mul_a: MA_X, mul_b: MB_RECIP, wr: WR_NONE};
        unique case (step)
            ST_WAIT: begin
                w.cond   = COND_WAIT_IN;
                w.target = ST_WAIT;
                w.wr     = WR_IN;
            end
            ST_TMUL: begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_X;
                w.mul_b  = MB_RECIP;
            end
            ST_TFIX: begin
                w.wr = WR_T;
            end
            ST_GMUL: begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_GRAV;
                w.mul_b  = MB_SINE;
            end
            ST_VTMUL: begin
                w.wr     = WR_AMAG;
                w.mul_en = 1'b1;
                w.mul_a  = MA_VMAG;
                w.mul_b  = MB_TIME;
            end
            ST_ATMUL: begin
                w.wr     = WR_VT;
                w.mul_en = 1'b1;
                w.mul_a  = MA_AMAG;
                w.mul_b  = MB_TIME;
            end
            ST_DMUL: begin
                w.wr     = WR_AT;
                w.mul_en = 1'b1;
                w.mul_a  = MA_VMAG;
                w.mul_b  = MB_REB;
            end
            ST_HMUL: begin
                w.wr     = WR_DAMP;
                w.mul_en = 1'b1;
                w.mul_a  = MA_ATMAG;
                w.mul_b  = MB_TIME;
            end
            ST_HALF: begin
                w.wr = WR_HALF;
            end
            ST_SUM: begin
                w.wr = WR_SUM;
            end
            ST_POS: begin
                w.wr = WR_POS;
            end
            ST_UPD: begin
                w.wr     = WR_STATE;
                w.cond   = COND_AXIS_FIRST;
                w.target = ST_GMUL;
            end
            ST_OUT: begin
                w.wr     = WR_OUT;
                w.cond   = COND_OUT_BUSY;
                w.target = ST_OUT;
                w.last   = 1'b1;
            end
            default: begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/tilt_ball_bounce_step_unit.sv
// ----------------------------------------------------------------------------
// tilt_ball_bounce_step_unit: one ball physics step per input transaction
// accepts no new transaction until the last one has reached the output register;
// the work is a 13-step microprogram around one shared 32x28 multiplier
// whose 9-step axis routine runs once per axis; output waits stall the program
// synchronous active-low aresetn restores registers and ball state at once
// ----------------------------------------------------------------------------
`default_nettype none

`include "tilt_ball_bounce_step_unit_defines.svh"

module tilt_ball_bounce_step_unit #(
    parameter int BALL_RADIUS  = 8,
    parameter int FIELD_WIDTH  = 320,
    parameter int FIELD_HEIGHT = 240
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [31:0]                       s_tdata,   // dt_ticks, tilt_x, tilt_y
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [23:0]                            m_tdata,   // pos_x, pos_y, hit_x, hit_y
    // config port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tbbs_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    // wall limits per axis: far wall test is p >= n-1-r, clamp at max(n-1-r, 0)
    localparam int FAR_LIM_X = FIELD_WIDTH - 1 - BALL_RADIUS;
    localparam int FAR_LIM_Y = FIELD_HEIGHT - 1 - BALL_RADIUS;
    localparam int FAR_POS_X = (FAR_LIM_X < 0) ? 0 : FAR_LIM_X;
    localparam int FAR_POS_Y = (FAR_LIM_Y < 0) ? 0 : FAR_LIM_Y;

    // ------------------------------------------------------------------
    // config registers
    // ------------------------------------------------------------------
    logic [tbbs_pkg::GRAV_W-1:0] gravity_reg;
    logic [tbbs_pkg::REB_W-1:0]  rebound_reg;
    logic [tbbs_pkg::STOP_W-1:0] stop_reg;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gravity_reg <= tbbs_pkg::GRAVITY_RST;
            rebound_reg <= tbbs_pkg::REBOUND_RST;
            stop_reg    <= tbbs_pkg::STOP_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                tbbs_pkg::REG_GRAVITY: gravity_reg <= pwdata[tbbs_pkg::GRAV_W-1:0];
                tbbs_pkg::REG_REBOUND: rebound_reg <= pwdata[tbbs_pkg::REB_W-1:0];
                tbbs_pkg::REG_STOP:    stop_reg    <= pwdata[tbbs_pkg::STOP_W-1:0];
                default: begin
                    // unmapped address, write dropped
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[3:2])
            tbbs_pkg::REG_GRAVITY: prdata = {16'b0, gravity_reg};
            tbbs_pkg::REG_REBOUND: prdata = {23'b0, rebound_reg};
            tbbs_pkg::REG_STOP:    prdata = {16'b0, stop_reg};
            default:               prdata = 32'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: step counter plus control word from the microcode table
    // ------------------------------------------------------------------
    logic [tbbs_pkg::STEP_W-1:0] step_reg;
    logic [tbbs_pkg::STEP_W-1:0] step_next;
    tbbs_pkg::ctrl_t             ctrl;
    logic                        axis_reg;      // 0 = x axis, 1 = y axis
    logic                        m_tvalid_reg;
    logic                        cond_hit;
    logic                        hold;
    logic                        go;

    assign ctrl = tbbs_pkg::ucode(step_reg);

    always_comb begin
        case (ctrl.cond)
            tbbs_pkg::COND_WAIT_IN:    cond_hit = !s_tvalid;
            tbbs_pkg::COND_OUT_BUSY:   cond_hit = m_tvalid_reg && !m_tready;
            tbbs_pkg::COND_AXIS_FIRST: cond_hit = !axis_reg;
            default:                   cond_hit = 1'b0;
        endcase
    end

    // wait conditions loop on their own step, the axis condition branches back
    assign hold = cond_hit && (ctrl.cond == tbbs_pkg::COND_WAIT_IN ||
                               ctrl.cond == tbbs_pkg::COND_OUT_BUSY);
    assign go   = !hold;

    always_comb begin
        if (cond_hit) begin
            step_next = ctrl.target;
        end else if (ctrl.last) begin
            step_next = tbbs_pkg::ST_WAIT;
        end else begin
            step_next = step_reg + tbbs_pkg::STEP_W'(1);
        end
    end

    // ready only in the wait step; a pending result does not block it
    assign s_tready = (ctrl.cond == tbbs_pkg::COND_WAIT_IN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= tbbs_pkg::ST_WAIT;
            axis_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            if (go && ctrl.wr == tbbs_pkg::WR_STATE) begin
                axis_reg <= ~axis_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // input latch
    // ------------------------------------------------------------------
    logic        [tbbs_pkg::DT_W-1:0]   dt_reg;
    logic signed [tbbs_pkg::TILT_W-1:0] tilt_reg [0:1];

    always_ff @(posedge aclk) begin
        if (go && ctrl.wr == tbbs_pkg::WR_IN) begin
            dt_reg      <= s_tdata[9:0];
            tilt_reg[0] <= s_tdata[17:10];
            tilt_reg[1] <= s_tdata[25:18];
        end
    end

    // ------------------------------------------------------------------
    // ball state per axis
    // ------------------------------------------------------------------
    logic        [tbbs_pkg::POS_W-1:0] pos_reg    [0:1];
    logic signed [tbbs_pkg::VEL_W-1:0] vel_reg    [0:1];
    logic                              bounce_reg [0:1];
    logic                              hit_reg    [0:1];

    // current axis velocity, sign and true magnitude (min int is 2^31)
    logic signed [tbbs_pkg::VEL_W-1:0] vel_cur;
    logic                              v_neg;
    logic        [tbbs_pkg::VEL_W-1:0] v_mag;

    assign vel_cur = vel_reg[axis_reg];
    assign v_neg   = vel_cur[tbbs_pkg::VEL_W-1];
    assign v_mag   = v_neg ? tbbs_pkg::VEL_W'(-vel_cur) : vel_cur;

    // ------------------------------------------------------------------
    // tilt to sine lookup, tilt saturates at +-70
    // ------------------------------------------------------------------
    logic signed [tbbs_pkg::TILT_W-1:0] tilt_cur;
    logic                               a_neg;
    logic        [tbbs_pkg::TILT_W-1:0] tilt_abs;
    logic        [tbbs_pkg::MAG_W-1:0]  tilt_mag;
    logic        [tbbs_pkg::SINE_W-1:0] sine_val;

    assign tilt_cur = tilt_reg[axis_reg];
    assign a_neg    = tilt_cur[tbbs_pkg::TILT_W-1];
    assign tilt_abs = a_neg ? tbbs_pkg::TILT_W'(-tilt_cur) : tilt_cur;
    assign tilt_mag = (tilt_abs > tbbs_pkg::TILT_W'(tbbs_pkg::TILT_MAX)) ?
                      tbbs_pkg::MAG_W'(tbbs_pkg::TILT_MAX) : tilt_abs[tbbs_pkg::MAG_W-1:0];
    assign sine_val = tbbs_pkg::SINE_OF_TILT[tilt_mag];

    // ------------------------------------------------------------------
    // shared multiplier, all operands are magnitudes, signs tracked apart
    // ------------------------------------------------------------------
    logic [tbbs_pkg::PROD_W-1:0]  prod_reg;
    logic [tbbs_pkg::T_W-1:0]     t_reg;
    logic [tbbs_pkg::AMAG_W-1:0]  a_mag_reg;
    logic [tbbs_pkg::ATMAG_W-1:0] at_mag_reg;
    logic [tbbs_pkg::VT_W-1:0]    vt_mag_reg;
    logic [tbbs_pkg::DAMP_W-1:0]  damp_mag_reg;
    logic [tbbs_pkg::HALF_W-1:0]  half_mag_reg;
    logic [tbbs_pkg::MUL_A_W-1:0] mul_a_val;
    logic [tbbs_pkg::MUL_B_W-1:0] mul_b_val;

    always_comb begin
        unique case (ctrl.mul_a)
            tbbs_pkg::MA_X:     mul_a_val = {6'b0, dt_reg, 16'b0};
            tbbs_pkg::MA_GRAV:  mul_a_val = {16'b0, gravity_reg};
            tbbs_pkg::MA_AMAG:  mul_a_val = {8'b0, a_mag_reg};
            tbbs_pkg::MA_VMAG:  mul_a_val = v_mag;
            tbbs_pkg::MA_ATMAG: mul_a_val = {2'b0, at_mag_reg};
            default:            mul_a_val = '0;
        endcase
    end

    always_comb begin
        unique case (ctrl.mul_b)
            tbbs_pkg::MB_RECIP: mul_b_val = tbbs_pkg::TIME_RECIP;
            tbbs_pkg::MB_SINE:  mul_b_val = {12'b0, sine_val};
            tbbs_pkg::MB_TIME:  mul_b_val = {6'b0, t_reg};
            tbbs_pkg::MB_REB:   mul_b_val = {19'b0, rebound_reg};
            default:            mul_b_val = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (go && ctrl.mul_en) begin
            prod_reg <= {28'b0, mul_a_val} * {32'b0, mul_b_val};
        end
    end

    // ------------------------------------------------------------------
    // t = floor(dt * 2^16 / 30): reciprocal estimate is low by at most one
    // ------------------------------------------------------------------
    logic [25:0]              x_val;
    logic [tbbs_pkg::T_W-1:0] q_est;
    logic [26:0]              q_x30;
    logic [26:0]              q_rem;
    logic [tbbs_pkg::T_W-1:0] t_next;

    assign x_val  = {dt_reg, 16'b0};
    assign q_est  = prod_reg[53:32];
    assign q_x30  = {q_est, 5'b0} - {4'b0, q_est, 1'b0};
    assign q_rem  = {1'b0, x_val} - q_x30;
    assign t_next = (q_rem >= 27'(tbbs_pkg::TIME_DIV)) ? q_est + tbbs_pkg::T_W'(1) : q_est;

    // ------------------------------------------------------------------
    // displacement sum and candidate position, both round toward zero
    // ------------------------------------------------------------------
    logic signed [tbbs_pkg::SUM_W-1:0] sum_reg;
    logic signed [tbbs_pkg::SUM_W-1:0] pos_ext;
    logic signed [tbbs_pkg::SUM_W-1:0] vt_s;
    logic signed [tbbs_pkg::SUM_W-1:0] half_s;
    logic signed [tbbs_pkg::SUM_W-1:0] sum_next;
    logic        [tbbs_pkg::SUM_W-1:0] sum_abs;
    logic        [tbbs_pkg::P_W-1:0]   p_mag;
    logic signed [tbbs_pkg::P_W-1:0]   p_next;
    logic signed [tbbs_pkg::P_W-1:0]   p_reg;

    assign pos_ext  = $signed({14'b0, pos_reg[axis_reg], 16'b0});
    assign vt_s     = v_neg ? -$signed({3'b0, vt_mag_reg}) : $signed({3'b0, vt_mag_reg});
    assign half_s   = a_neg ? -$signed({5'b0, half_mag_reg}) : $signed({5'b0, half_mag_reg});
    assign sum_next = pos_ext + vt_s + half_s;

    assign sum_abs = sum_reg[tbbs_pkg::SUM_W-1] ? tbbs_pkg::SUM_W'(-sum_reg) : sum_reg;
    assign p_mag   = sum_abs[tbbs_pkg::SUM_W-1:16];
    assign p_next  = sum_reg[tbbs_pkg::SUM_W-1] ? -$signed(p_mag) : $signed(p_mag);

    // ------------------------------------------------------------------
    // wall tests and velocity update
    // ------------------------------------------------------------------
    logic signed [tbbs_pkg::P_W-1:0]    far_lim;
    logic signed [tbbs_pkg::P_W-1:0]    near_lim;
    logic        [tbbs_pkg::POS_W-1:0]  far_pos;
    logic                               wall_far;
    logic                               wall_hit;
    logic signed [30:0]                 at_s;
    logic signed [33:0]                 neg_damp;
    logic signed [tbbs_pkg::VSUM_W-1:0] bounce_sum;
    logic signed [tbbs_pkg::VSUM_W-1:0] coast_sum;
    logic                               stop_now;

    assign far_lim  = axis_reg ? tbbs_pkg::P_W'(FAR_LIM_Y) : tbbs_pkg::P_W'(FAR_LIM_X);
    assign near_lim = tbbs_pkg::P_W'(BALL_RADIUS);
    assign far_pos  = axis_reg ? tbbs_pkg::POS_W'(FAR_POS_Y) : tbbs_pkg::POS_W'(FAR_POS_X);
    assign wall_far = (p_reg >= far_lim);
    assign wall_hit = wall_far || (p_reg < near_lim);

    assign at_s       = a_neg ? -$signed({1'b0, at_mag_reg}) : $signed({1'b0, at_mag_reg});
    assign neg_damp   = v_neg ? $signed({2'b0, damp_mag_reg}) : -$signed({2'b0, damp_mag_reg});
    assign bounce_sum = {neg_damp[33], neg_damp} + {{4{at_s[30]}}, at_s};
    assign coast_sum  = {{3{vel_cur[31]}}, vel_cur} + {{4{at_s[30]}}, at_s};
    assign stop_now   = bounce_reg[axis_reg] && (v_mag < {8'b0, stop_reg, 8'b0});

    function automatic logic signed [tbbs_pkg::VEL_W-1:0] sat_vel(
        input logic signed [tbbs_pkg::VSUM_W-1:0] v
    );
        logic same_top;
        same_top = (v[tbbs_pkg::VSUM_W-1:tbbs_pkg::VEL_W-1] == '0) ||
                   (v[tbbs_pkg::VSUM_W-1:tbbs_pkg::VEL_W-1] == '1);
        if (same_top) begin
            return v[tbbs_pkg::VEL_W-1:0];
        end else if (v[tbbs_pkg::VSUM_W-1]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7FFF_FFFF;
        end
    endfunction

    // ------------------------------------------------------------------
    // datapath writeback, selected by the control word
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (go) begin
            case (ctrl.wr)
                tbbs_pkg::WR_T:    t_reg        <= t_next;
                tbbs_pkg::WR_AMAG: a_mag_reg    <= prod_reg[31:8];
                tbbs_pkg::WR_VT:   vt_mag_reg   <= prod_reg[52:16];
                tbbs_pkg::WR_AT:   at_mag_reg   <= prod_reg[45:16];
                tbbs_pkg::WR_DAMP: damp_mag_reg <= prod_reg[39:8];
                tbbs_pkg::WR_HALF: half_mag_reg <= prod_reg[51:17];
                tbbs_pkg::WR_SUM:  sum_reg      <= sum_next;
                tbbs_pkg::WR_POS:  p_reg        <= p_next;
                default: begin
                    // no datapath write in this step
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg[0]    <= tbbs_pkg::BALL_X_RST;
            pos_reg[1]    <= tbbs_pkg::BALL_Y_RST;
            vel_reg[0]    <= '0;
            vel_reg[1]    <= '0;
            bounce_reg[0] <= 1'b0;
            bounce_reg[1] <= 1'b0;
            hit_reg[0]    <= 1'b0;
            hit_reg[1]    <= 1'b0;
        end else if (go && ctrl.wr == tbbs_pkg::WR_STATE) begin
            if (wall_hit) begin
                // clamp at the wall, reflect and damp
                pos_reg[axis_reg]    <= wall_far ? far_pos : tbbs_pkg::POS_W'(BALL_RADIUS);
                vel_reg[axis_reg]    <= sat_vel(bounce_sum);
                bounce_reg[axis_reg] <= 1'b1;
                hit_reg[axis_reg]    <= 1'b1;
            end else begin
                pos_reg[axis_reg] <= p_reg[tbbs_pkg::POS_W-1:0];
                hit_reg[axis_reg] <= 1'b0;
                if (stop_now) begin
                    // slow after a bounce: come to rest
                    vel_reg[axis_reg]    <= '0;
                    bounce_reg[axis_reg] <= 1'b0;
                end else begin
                    vel_reg[axis_reg] <= sat_vel(coast_sum);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output register, holds a result while the next item is worked on
    // ------------------------------------------------------------------
    logic [23:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (go && ctrl.wr == tbbs_pkg::WR_OUT) begin
                m_tvalid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go && ctrl.wr == tbbs_pkg::WR_OUT) begin
            m_tdata_reg <= {5'b0, hit_reg[1], hit_reg[0],
                            pos_reg[1][tbbs_pkg::POS_Y_W-1:0],
                            pos_reg[0][tbbs_pkg::POS_X_W-1:0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `TBBS_ASSERT_NEXT(a_accept_starts, aclk, aresetn, s_tvalid && s_tready, step_reg == tbbs_pkg::ST_TMUL)
    `TBBS_ASSERT_NOW(a_wait_on_x, aclk, aresetn, step_reg == tbbs_pkg::ST_WAIT, !axis_reg)
    `TBBS_ASSERT_NEXT(a_axis_flips, aclk, aresetn, step_reg == tbbs_pkg::ST_UPD, axis_reg != $past(axis_reg))
    `TBBS_ASSERT_NOW(a_out_from_step, aclk, aresetn, $rose(m_tvalid_reg), $past(step_reg) == tbbs_pkg::ST_OUT)

endmodule

`default_nettype wire

// File: tb/tb_tilt_ball_bounce_step_unit.sv
// ----------------------------------------------------------------------------
// tb_tilt_ball_bounce_step_unit
// drives tilt/time steps into the ball physics unit over its input stream,
// keeps its own fixed-point copy of the ball state and gravity/rebound/stop
// registers, and checks every position/hit transaction in order; registers
// are written and read back over the config port between phases
// ----------------------------------------------------------------------------

module tb_tilt_ball_bounce_step_unit;

    // geometry of the instance under test (module defaults)
    localparam int RADIUS      = 8;
    localparam int WIDTH_PX    = 320;
    localparam int HEIGHT_PX   = 240;
    localparam int TILT_LIMIT  = 70;

    // receiver hold-off that fills the unit and stalls its input
    localparam int LONG_HOLD   = 300;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_STEPS = 140;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // dt_ticks [9:0], tilt_x [17:10], tilt_y [25:18], zero fill
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // pos_x [8:0], pos_y [16:9], hit_x [17], hit_y [18], zero fill
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [tbbs_pkg::APB_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // handshake knobs: steady_flow for the sender and the receiver, hold_results for the receiver
    bit steady_flow;
    bit hold_results;

    typedef struct {
        logic [8:0] pos_x;
        logic [7:0] pos_y;
        logic       hit_x;
        logic       hit_y;
    } step_result_t;

    // ------------------------------------------------------------------------
    // ball state tracker and result checker
    // ------------------------------------------------------------------------
    class bounce_scoreboard;
        logic [15:0]  gravity;
        logic [8:0]   rebound;
        logic [15:0]  stop_level;
        longint       ball_pos [2];
        int           speed [2];
        bit           bounced [2];
        int unsigned  sine_by_angle [0:90];
        step_result_t expected_steps [$];
        int           failures;

        function new();
            gravity    = tbbs_pkg::GRAVITY_RST;
            rebound    = tbbs_pkg::REBOUND_RST;
            stop_level = tbbs_pkg::STOP_RST;
            ball_pos[0] = 160;
            ball_pos[1] = 120;
            speed[0]   = 0;
            speed[1]   = 0;
            bounced[0] = 0;
            bounced[1] = 0;
            failures   = 0;
            for (int k = 0; k <= 90; k++) begin
                sine_by_angle[k] = sine_q16_of(k);
            end
        endfunction

        // sin(k * 0.017) via fixed Taylor series in Q2.30, rounded to Q0.16
        function int unsigned sine_q16_of(int k);
            logic [63:0] x;
            logic [63:0] x2;
            logic [63:0] term;
            logic [63:0] r;
            longint      acc;
            x    = ((64'(k) * 64'd17) << 30) / 64'd1000;
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            for (int n = 1; n <= 7; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
            end
            if (acc < 0) begin
                acc = 0;
            end
            r = (64'(acc) + 64'd8192) >> 14;
            return (r > 64'd65535) ? 65535 : int'(r);
        endfunction

        function longint shift_toward_zero(longint v, int s);
            logic [63:0] m;
            m = (v < 0) ? 64'(-v) : 64'(v);
            m = m >> s;
            return (v < 0) ? -longint'(m) : longint'(m);
        endfunction

        function int clamp_speed(longint v);
            if (v > 64'sd2147483647) begin
                return 32'sh7FFFFFFF;
            end
            if (v < -64'sd2147483648) begin
                return 32'sh80000000;
            end
            return int'(v);
        endfunction

        // signed Q16.16 acceleration for one tilt reading
        function longint tilt_accel(logic [7:0] raw);
            int     tl;
            int     mag;
            longint a;
            tl = int'($signed(raw));
            if (tl > TILT_LIMIT) begin
                tl = TILT_LIMIT;
            end
            if (tl < -TILT_LIMIT) begin
                tl = -TILT_LIMIT;
            end
            mag = (tl < 0) ? -tl : tl;
            a   = (longint'(gravity) * longint'(sine_by_angle[(mag * 90) / 70])) >> 8;
            return (tl < 0) ? -a : a;
        endfunction

        // one axis of the step; returns the wall hit
        function bit advance_axis(int axis, longint accel, longint t, longint size);
            longint at;
            longint half;
            longint vt;
            longint p;
            longint far_pos;
            longint damped;
            longint vmag;
            at      = shift_toward_zero(accel * t, 16);
            half    = shift_toward_zero(at * t, 17);
            vt      = shift_toward_zero(longint'(speed[axis]) * t, 16);
            p       = shift_toward_zero(ball_pos[axis] * 65536 + vt + half, 16);
            far_pos = size - 1 - RADIUS;
            if (far_pos < 0) begin
                far_pos = 0;
            end
            if (p + RADIUS >= size - 1 || p - RADIUS < 0) begin
                damped = shift_toward_zero(longint'(speed[axis]) * longint'(rebound), 8);
                ball_pos[axis] = (p + RADIUS >= size - 1) ? far_pos : RADIUS;
                speed[axis]    = clamp_speed(at - damped);
                bounced[axis]  = 1;
                return 1;
            end
            ball_pos[axis] = p;
            vmag = (speed[axis] < 0) ? -longint'(speed[axis]) : longint'(speed[axis]);
            if (bounced[axis] && vmag < longint'(stop_level) * 256) begin
                speed[axis]   = 0;
                bounced[axis] = 0;
            end else begin
                speed[axis] = clamp_speed(longint'(speed[axis]) + at);
            end
            return 0;
        endfunction

        function void set_register(logic [tbbs_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
            case (idx)
                tbbs_pkg::REG_GRAVITY: gravity    = value[15:0];
                tbbs_pkg::REG_REBOUND: rebound    = value[8:0];
                tbbs_pkg::REG_STOP:    stop_level = value[15:0];
                default: ;
            endcase
        endfunction

        // accepted input transaction: advance the ball and queue its position
        function void note_tilt_step(logic [9:0] dt, logic [7:0] tx, logic [7:0] ty);
            longint       t;
            longint       ax;
            longint       ay;
            step_result_t want;
            t  = (longint'(dt) << 16) / 30;
            ax = tilt_accel(tx);
            ay = tilt_accel(ty);
            want.hit_x = advance_axis(0, ax, t, WIDTH_PX);
            want.hit_y = advance_axis(1, ay, t, HEIGHT_PX);
            want.pos_x = ball_pos[0][8:0];
            want.pos_y = ball_pos[1][7:0];
            expected_steps.push_back(want);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_position(logic [23:0] data);
            step_result_t want;
            if (expected_steps.size() == 0) begin
                $display("%0t: result with no step pending, expected none actual %h",
                         $time, data);
                failures++;
                return;
            end
            want = expected_steps.pop_front();
            compare_field("pos_x", want.pos_x, data[8:0]);
            compare_field("pos_y", want.pos_y, data[16:9]);
            compare_field("hit_x", want.hit_x, data[17]);
            compare_field("hit_y", want.hit_y, data[18]);
        endfunction

        function int pending();
            return expected_steps.size();
        endfunction
    endclass

    bounce_scoreboard board;

    tilt_ball_bounce_step_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result monitor: every output transaction is checked at the edge it happens
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_position(m_tdata);
        end
    end

    // result sink: random or no stall per transaction, one long hold on request
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_results) begin
                // counted here while the sender keeps offering steps
                stall        = LONG_HOLD;
                hold_results = 1'b0;
            end else if (steady_flow) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 15);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // one input transaction; entered and left at a falling edge with tvalid still
    // high, so back-to-back steps never lower and raise it in the same step
    task automatic send_step(logic [9:0] dt, logic [7:0] tx, logic [7:0] ty);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {6'd0, ty, tx, dt};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        board.note_tilt_step(dt, tx, ty);
        @(negedge aclk);
    endtask

    // sender pause: withdraw tvalid and wait for every queued position
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // register write then read-back, as one continuous selected access pair
    task automatic write_register(logic [tbbs_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
        logic [31:0] want;
        want    = (idx == tbbs_pkg::REG_REBOUND) ? (value & 32'h1FF) : (value & 32'hFFFF);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= tbbs_pkg::APB_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        board.set_register(idx, value);
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) begin
            $display("%0t: register %0d readback mismatch, expected %h actual %h",
                     $time, idx, want, prdata);
            board.failures++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        // idle with psel low before the next access
        @(negedge aclk);
    endtask

    initial begin : stimulus
        logic [9:0]  dt;
        logic [7:0]  tx;
        logic [7:0]  ty;
        logic [15:0] grav;
        logic [8:0]  reb;
        logic [15:0] stop;
        board        = new();
        steady_flow  = 1'b0;
        hold_results = 1'b0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed steps on the reset register values
        send_step(10'd0,    8'sd0,    8'sd0);      // no time, no tilt
        send_step(10'd30,   8'sd0,    8'sd0);      // ball at rest stays put
        send_step(10'd1023, 8'sd70,  -8'sd70);     // huge move onto far x / near y
        send_step(10'd1023, -8'sd70,  8'sd70);     // and back across the field
        send_step(10'd0,    8'sd127, -8'sd128);    // tilt beyond range saturates
        send_step(10'd341,  8'sd71,  -8'sd71);
        send_step(10'd682,  -8'sd71,  8'sd71);
        send_step(10'd1,    8'sd1,   -8'sd1);
        send_step(10'd512,  -8'sd1,   8'sd1);
        send_step(10'd15,   8'sd35,  -8'sd35);
        send_step(10'd1023, 8'sd127,  8'sd127);
        send_step(10'd1023, -8'sd128, -8'sd128);
        send_step(10'd600,  8'sd0,    8'sd0);      // coast after the bounce
        send_step(10'd30,   8'sd0,    8'sd0);
        send_step(10'd30,   8'sd0,    8'sd0);      // slow after bounce, may stop
        send_step(10'd300,  8'sd10,  -8'sd10);
        send_step(10'd5,    8'sd69,  -8'sd69);
        send_step(10'd60,   -8'sd70, -8'sd70);
        send_step(10'd60,   8'sd70,   8'sd70);
        send_step(10'd0,    -8'sd1,   8'sd1);
        send_step(10'd512,  -8'sd64,  8'sd64);
        send_step(10'd90,   8'sd20,   8'sd40);
        send_step(10'd45,   -8'sd50, -8'sd30);
        send_step(10'd200,  8'sd0,   -8'sd70);

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            drain_results();
            case (phase)
                0: begin grav = 16'd0;     reb = 9'd0;   stop = 16'd0;     end
                1: begin grav = 16'hFFFF;  reb = 9'd511; stop = 16'hFFFF;  end
                2: begin grav = 16'hFFFF;  reb = 9'd256; stop = 16'd0;     end
                3: begin
                    grav = tbbs_pkg::GRAVITY_RST;
                    reb  = tbbs_pkg::REBOUND_RST;
                    stop = tbbs_pkg::STOP_RST;
                end
                4, 5: begin
                    grav = 16'($urandom_range(0, 6000));
                    reb  = 9'($urandom_range(0, 511));
                    stop = 16'($urandom_range(0, 65535));
                end
                default: begin
                    grav = 16'($urandom_range(0, 65535));
                    reb  = 9'($urandom_range(0, 511));
                    stop = 16'($urandom_range(0, 4096));
                end
            endcase
            write_register(tbbs_pkg::REG_GRAVITY, 32'(grav));
            write_register(tbbs_pkg::REG_REBOUND, 32'(reb));
            write_register(tbbs_pkg::REG_STOP, 32'(stop));

            // back-to-back stretches on both sides in two phases
            steady_flow = (phase == 2 || phase == 6);
            // long receiver hold with the sender still pushing
            if (phase == 4) begin
                hold_results = 1'b1;
            end

            for (int i = 0; i < PHASE_STEPS; i++) begin
                // sender waits for the pipeline to empty mid-phase
                if (phase == 5 && i == PHASE_STEPS / 2) begin
                    drain_results();
                end
                // mostly short frames, sometimes anything the field allows
                case ($urandom_range(0, 19))
                    0, 1:    dt = 10'($urandom_range(0, 1023));
                    2, 3, 4: dt = 10'($urandom_range(0, 200));
                    default: dt = 10'($urandom_range(0, 60));
                endcase
                tx = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 140) - 70)
                                                  : 8'($urandom_range(0, 255));
                ty = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 140) - 70)
                                                  : 8'($urandom_range(0, 255));
                send_step(dt, tx, ty);
            end
        end

        drain_results();
        steady_flow = 1'b0;
        // settle time past the unit's latency before the verdict
        repeat (30) @(posedge aclk);
        if (board.failures == 0 && board.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/tbbs_pkg.sv
rtl/core/tilt_ball_bounce_step_unit.sv
tb/tb_tilt_ball_bounce_step_unit.sv
